// ===== design/tasp_pkg.sv =====
// Shared types and constants of the transient alias slot planner.
`timescale 1ns / 1ps
package tasp_pkg;
    localparam int MaxResourcesDefault = 32;

    localparam logic [1:0] KindAssign  = 2'd0;
    localparam logic [1:0] KindSummary = 2'd1;
    localparam logic [1:0] KindError   = 2'd2;

    localparam logic [2:0] StatOk       = 3'd0;
    localparam logic [2:0] StatLifetime = 3'd1;
    localparam logic [2:0] StatDup      = 3'd2;
    localparam logic [2:0] StatOverflow = 3'd3;
    localparam logic [2:0] StatTooMany  = 3'd4;

    localparam int InWidth  = 200;
    localparam int OutWidth = 184;

    // One stored lifetime as it travels from the front part to the back part.
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] first;
        logic [31:0] final_p;
        logic [63:0] size;
        logic [31:0] key;
        logic        transient;
        logic        alias_ok;
    } t_entry;

    // Control item of the queue: one entry, with flags for the end of a plan and too many entries.
    typedef struct packed {
        logic   is_end;
        logic   too_many;
        t_entry ent;
    } t_qitem;
endpackage

// ===== design/transient_alias_slot_planner.sv =====
// Top level of the transient alias slot planner.
`timescale 1ns / 1ps
// Usage:
// Lifetimes enter on s_axis, one per item; tlast marks the last one of a plan.
// Results leave on m_axis: tuser is the kind (assignment, summary, error),
// tlast marks the summary or the error that ends a plan.
// Items are loaded while the back part is idle and its output register is free.
// After the last item the back part validates, sorts by insertion, searches slots,
// sums and emits N+1 results, one per cycle when the receiver is ready. A single
// sequencer works through these steps on the shared entry store.
// A two-entry queue separates input from the sequencer; s_axis stalls once the queue
// is full while a plan is worked on or while a result waits in the output register.
// When the receiver holds tready low the result register keeps its item and the
// sequencer waits when it has a new result to load. Reset empties the queue, clears
// the entry count and the error flag; stored entries are not cleared.
module transient_alias_slot_planner
    import tasp_pkg::*;
#(
    parameter int MAX_RESOURCES = MaxResourcesDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // id, first pass, final pass, size, transient flag, alias flag, key
    input  logic [InWidth-1:0]  s_axis_tdata,
    input  logic                s_axis_tlast,    // last_entry
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // id, slot, resource count, used slots, total bytes, heap bytes, status
    output logic [OutWidth-1:0] m_axis_tdata,
    output logic [1:0]          m_axis_tuser,    // kind
    output logic                m_axis_tlast     // last_result
);
    logic   w_fv, w_fr, w_fs, w_bv, w_br, w_bs;
    t_qitem w_fi, w_bi;

    tasp_front #(.MAX_RESOURCES(MAX_RESOURCES)) u_front (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .o_q_valid(w_fv), .i_q_ready(w_fr), .o_q_item(w_fi), .o_q_store(w_fs));

    tasp_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_item(w_fi), .i_store(w_fs),
        .o_valid(w_bv), .i_ready(w_br), .o_item(w_bi), .o_store(w_bs));

    tasp_back #(.MAX_RESOURCES(MAX_RESOURCES)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_bv), .o_q_ready(w_br), .i_q_item(w_bi),
        .i_q_store(w_bs), .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .m_axis_tlast);
endmodule

// ===== design/tasp_front.sv =====
// Front part: accepts input items, unpacks and counts them and marks plan ends.
`timescale 1ns / 1ps
module tasp_front
    import tasp_pkg::*;
#(
    parameter int MAX_RESOURCES = MaxResourcesDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InWidth-1:0]  s_axis_tdata,   // id, first, final, size, transient, alias, key
    input  logic                s_axis_tlast,
    output logic                o_q_valid,
    input  logic                i_q_ready,
    output t_qitem              o_q_item,
    output logic                o_q_store      // entry is to be stored
);
    localparam int CW = $clog2(MAX_RESOURCES + 1);
    logic [CW-1:0] r_count, n_count;
    logic          r_err, n_err;
    logic          w_room;

    assign w_room        = (r_count < CW'(MAX_RESOURCES));
    assign s_axis_tready = i_q_ready;
    assign o_q_valid     = s_axis_tvalid;
    assign o_q_store     = w_room;

    always_comb begin
        o_q_item.ent.id        = s_axis_tdata[31:0];
        o_q_item.ent.first     = s_axis_tdata[63:32];
        o_q_item.ent.final_p   = s_axis_tdata[95:64];
        o_q_item.ent.size      = s_axis_tdata[159:96];
        o_q_item.ent.transient = s_axis_tdata[160];
        o_q_item.ent.alias_ok  = s_axis_tdata[161];
        o_q_item.ent.key       = s_axis_tdata[193:162];
        o_q_item.is_end        = s_axis_tlast;
        o_q_item.too_many      = r_err | ~w_room;
    end

    always_comb begin
        n_count = r_count;
        n_err   = r_err;
        if (s_axis_tvalid && i_q_ready) begin
            if (w_room) n_count = r_count + 1'b1;
            else n_err = 1'b1;
            if (s_axis_tlast) begin
                n_count = '0;
                n_err   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_err   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_err   <= n_err;
        end
    end
endmodule

// ===== design/tasp_queue.sv =====
// Two-entry queue between the front and the back part.
`timescale 1ns / 1ps
module tasp_queue
    import tasp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_qitem i_item,
    input  logic   i_store,
    output logic   o_valid,
    input  logic   i_ready,
    output t_qitem o_item,
    output logic   o_store
);
    t_qitem r_mem [2];
    logic   r_st  [2];
    logic   r_wp, r_rp;
    logic [1:0] r_cnt;
    logic   w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rp];
    assign o_store = r_st[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
            r_st[r_wp]  <= i_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== design/tasp_back.sv =====
// Back part: stores a plan, validates, sorts, assigns slots and emits results.
`timescale 1ns / 1ps
module tasp_back
    import tasp_pkg::*;
#(
    parameter int MAX_RESOURCES = MaxResourcesDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_ready,
    input  t_qitem              i_q_item,
    input  logic                i_q_store,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutWidth-1:0] m_axis_tdata,
    output logic [1:0]          m_axis_tuser,
    output logic                m_axis_tlast
);
    localparam int AW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int CW = $clog2(MAX_RESOURCES + 1);

    typedef enum logic [9:0] {
        S_LOAD  = 10'b0000000001,
        S_VAL   = 10'b0000000010,
        S_SORT  = 10'b0000000100,
        S_ASRD  = 10'b0000001000,
        S_SRCH  = 10'b0000010000,
        S_PLACE = 10'b0000100000,
        S_LSUM  = 10'b0001000000,
        S_HSUM  = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;
    t_entry r_ent   [MAX_RESOURCES];
    logic [AW-1:0] r_order [MAX_RESOURCES];
    logic [31:0] r_sfin [MAX_RESOURCES];
    logic [31:0] r_skey [MAX_RESOURCES];
    logic [63:0] r_sbytes [MAX_RESOURCES];
    logic        r_sreuse [MAX_RESOURCES];
    logic [AW-1:0] r_aslot [MAX_RESOURCES];

    logic [CW-1:0] r_n, r_i, r_j, r_nslots;
    logic [63:0]   r_logical, r_heap;
    t_entry        r_cur;
    logic [AW-1:0] r_cur_idx;

    // output register
    logic          r_ov;
    logic [1:0]    r_okind;
    logic [31:0]   r_oid;
    logic [4:0]    r_oslot;
    logic [5:0]    r_orc, r_osc;
    logic [63:0]   r_olb, r_ohb;
    logic [2:0]    r_ostat;
    logic          r_olast;

    logic w_out_free;
    assign w_out_free = !r_ov || m_axis_tready;
    assign o_q_ready  = (r_state == S_LOAD) && w_out_free;

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {4'b0, r_ostat, r_ohb, r_olb, r_osc, r_orc, r_oslot, r_oid};

    t_entry w_ei, w_ej, w_cs;
    assign w_ei = r_ent[r_i[AW-1:0]];
    assign w_ej = r_ent[r_j[AW-1:0]];
    assign w_cs = r_ent[r_order[r_j[AW-1:0] - 1'b1]];

    logic w_before;
    assign w_before = (r_cur.first != w_cs.first) ? (r_cur.first < w_cs.first)
                                                  : (r_cur.id < w_cs.id);
    logic w_alias;
    assign w_alias = r_cur.transient & r_cur.alias_ok;
    logic [64:0] w_lsum, w_hsum;
    assign w_lsum = {1'b0, r_logical} + {1'b0, w_ei.size};
    assign w_hsum = {1'b0, r_heap} + {1'b0, r_sbytes[r_i[AW-1:0]]};

    task automatic put(input logic [1:0] k, input logic [31:0] id, input logic [4:0] sl,
                       input logic [5:0] rc, input logic [5:0] sc, input logic [63:0] lb,
                       input logic [63:0] hb, input logic [2:0] st, input logic la);
        r_okind <= k; r_oid <= id; r_oslot <= sl; r_orc <= rc; r_osc <= sc;
        r_olb <= lb; r_ohb <= hb; r_ostat <= st; r_olast <= la;
    endtask

    always_ff @(posedge i_clk) begin : p_seq
        logic v_put;
        v_put = 1'b0;
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_ov     <= 1'b0;
            r_n      <= '0;
            r_nslots <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (i_q_valid && w_out_free) begin
                        if (i_q_store) begin
                            r_ent[r_n[AW-1:0]] <= i_q_item.ent;
                        end
                        if (i_q_item.is_end) begin
                            if (i_q_item.too_many) begin
                                put(KindError, '0, '0, '0, '0, '0, '0, StatTooMany, 1'b1);
                                v_put = 1'b1;
                                r_n  <= '0;
                            end else begin
                                r_n <= r_n + 1'b1;
                                r_i <= '0; r_j <= '0;
                                r_nslots <= '0;
                                r_state <= S_VAL;
                            end
                        end else if (i_q_store) begin
                            r_n <= r_n + 1'b1;
                        end
                    end
                end
                S_VAL: begin
                    // i walks entries; j walks earlier entries of i.
                    if (r_i == r_n) begin
                        r_order[0] <= '0;
                        r_i <= CW'(1);
                        r_state <= S_SORT;
                        r_j <= '0;
                    end else if (r_j == '0 &&
                                 (w_ei.size == '0 || w_ei.first > w_ei.final_p)) begin
                        if (w_out_free) begin
                            put(KindError, '0, '0, '0, '0, '0, '0, StatLifetime, 1'b1);
                            v_put = 1'b1; r_n <= '0; r_state <= S_LOAD;
                        end
                    end else if (r_j == r_i) begin
                        r_i <= r_i + 1'b1; r_j <= '0;
                    end else if (w_ej.id == w_ei.id) begin
                        if (w_out_free) begin
                            put(KindError, '0, '0, '0, '0, '0, '0, StatDup, 1'b1);
                            v_put = 1'b1; r_n <= '0; r_state <= S_LOAD;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_SORT: begin
                    // insertion sort: r_j == 0 loads the next element to insert
                    if (r_i == r_n) begin
                        r_i <= '0; r_nslots <= '0;
                        r_state <= S_ASRD;
                    end else if (r_j == '0) begin
                        r_cur <= w_ei;
                        r_cur_idx <= r_i[AW-1:0];
                        r_j <= r_i;
                    end else if (r_j != CW'(MAX_RESOURCES + 1) && w_before) begin
                        r_order[r_j[AW-1:0]] <= r_order[r_j[AW-1:0] - 1'b1];
                        if (r_j == CW'(1)) begin
                            r_order[0] <= r_cur_idx;
                            r_i <= r_i + 1'b1; r_j <= '0;
                        end else r_j <= r_j - 1'b1;
                    end else begin
                        r_order[r_j[AW-1:0]] <= r_cur_idx;
                        r_i <= r_i + 1'b1; r_j <= '0;
                    end
                end
                S_ASRD: begin
                    if (r_i == r_n) begin
                        r_i <= '0; r_logical <= '0;
                        r_state <= S_LSUM;
                    end else begin
                        r_cur_idx <= r_order[r_i[AW-1:0]];
                        r_cur <= r_ent[r_order[r_i[AW-1:0]]];
                        r_j <= '0;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (!w_alias || r_j == r_nslots) begin
                        r_state <= S_PLACE;
                        r_j <= r_nslots;
                    end else if (r_sreuse[r_j[AW-1:0]] && r_skey[r_j[AW-1:0]] == r_cur.key
                                 && r_sfin[r_j[AW-1:0]] < r_cur.first) begin
                        r_state <= S_PLACE;
                    end else r_j <= r_j + 1'b1;
                end
                S_PLACE: begin
                    if (r_j == r_nslots) begin
                        r_skey[r_j[AW-1:0]]   <= r_cur.key;
                        r_sbytes[r_j[AW-1:0]] <= r_cur.size;
                        r_sreuse[r_j[AW-1:0]] <= w_alias;
                        r_nslots <= r_nslots + 1'b1;
                    end else if (r_cur.size > r_sbytes[r_j[AW-1:0]]) begin
                        r_sbytes[r_j[AW-1:0]] <= r_cur.size;
                    end
                    r_sfin[r_j[AW-1:0]] <= r_cur.final_p;
                    r_aslot[r_cur_idx] <= r_j[AW-1:0];
                    r_i <= r_i + 1'b1;
                    r_state <= S_ASRD;
                end
                S_LSUM: begin
                    if (r_i == r_n) begin
                        r_i <= '0; r_heap <= '0; r_state <= S_HSUM;
                    end else if (w_lsum[64]) begin
                        if (w_out_free) begin
                            put(KindError, '0, '0, '0, '0, '0, '0, StatOverflow, 1'b1);
                            v_put = 1'b1; r_n <= '0; r_state <= S_LOAD;
                        end
                    end else begin
                        r_logical <= w_lsum[63:0]; r_i <= r_i + 1'b1;
                    end
                end
                S_HSUM: begin
                    if (r_i == r_nslots) begin
                        r_i <= '0; r_state <= S_EMIT;
                    end else if (w_hsum[64]) begin
                        if (w_out_free) begin
                            put(KindError, '0, '0, '0, '0, '0, '0, StatOverflow, 1'b1);
                            v_put = 1'b1; r_n <= '0; r_state <= S_LOAD;
                        end
                    end else begin
                        r_heap <= w_hsum[63:0]; r_i <= r_i + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        v_put = 1'b1;
                        if (r_i == r_n) begin
                            put(KindSummary, '0, '0, 6'(r_n), 6'(r_nslots), r_logical,
                                r_heap, StatOk, 1'b1);
                            r_n <= '0; r_state <= S_LOAD;
                        end else begin
                            put(KindAssign, w_ei.id, 5'(r_aslot[r_i[AW-1:0]]), '0, '0,
                                '0, '0, StatOk, 1'b0);
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_OUT: r_state <= S_LOAD;
                default: r_state <= S_LOAD;
            endcase
            // A new result is only loaded when the register is free.
            r_ov <= v_put || (r_ov && !m_axis_tready);
        end
    end

`ifndef SYNTHESIS
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(MAX_RESOURCES)) else $error("entry count too large");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_ready |-> r_state == S_LOAD) else $error("queue drained while busy");
    a_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nslots <= r_n || r_state == S_LOAD) else $error("more slots than entries");
`endif
endmodule
